/* hw/rtl/lcnc_pkg.sv */
// shared types, constants and helper functions for the luhn card number check
// no dependencies
`timescale 1ns / 1ps

package lcnc_pkg;

   localparam int CARD_WIDTH         = 63;
   localparam int CONV_WIDTH         = 64;
   localparam int SHIFT_STEP         = 4;
   localparam int CONV_CYCLES        = CONV_WIDTH / SHIFT_STEP;
   localparam int CONV_CNT_WIDTH     = $clog2(CONV_CYCLES);
   localparam int DIGIT_WIDTH        = 4;
   localparam int COUNT_WIDTH        = 5;
   localparam int BRAND_WIDTH        = 2;
   localparam int MAX_DIGITS_DEFAULT = 19;

   typedef enum logic [BRAND_WIDTH-1:0] {
      BRAND_NONE       = 2'd0,
      BRAND_AMEX       = 2'd1,
      BRAND_MASTERCARD = 2'd2,
      BRAND_VISA       = 2'd3
   } brand_type;

   typedef struct packed {
      logic clear;
      logic step;
   } acc_ctrl_type;

   typedef struct packed {
      logic                   sum_zero;
      logic [COUNT_WIDTH-1:0] count;
      logic [DIGIT_WIDTH-1:0] lead;
      logic [DIGIT_WIDTH-1:0] next;
   } acc_status_type;

   // doubled digit folded back to one digit
   function automatic logic [DIGIT_WIDTH-1:0] luhn_double(input logic [DIGIT_WIDTH-1:0] digit);
      logic [DIGIT_WIDTH-1:0] res;
      case (digit)
         4'd0:    res = 4'd0;
         4'd1:    res = 4'd2;
         4'd2:    res = 4'd4;
         4'd3:    res = 4'd6;
         4'd4:    res = 4'd8;
         4'd5:    res = 4'd1;
         4'd6:    res = 4'd3;
         4'd7:    res = 4'd5;
         4'd8:    res = 4'd7;
         4'd9:    res = 4'd9;
         default: res = 4'd0;
      endcase
      return res;
   endfunction

   function automatic brand_type classify(input logic [COUNT_WIDTH-1:0] count,
                                          input logic [DIGIT_WIDTH-1:0] lead,
                                          input logic [DIGIT_WIDTH-1:0] next);
      brand_type res;
      res = BRAND_NONE;
      if (count == 5'd15 && lead == 4'd3 && (next inside {4'd4, 4'd7})) begin
         res = BRAND_AMEX;
      end else if (count == 5'd16 && lead == 4'd5 && (next inside {[4'd1:4'd5]})) begin
         res = BRAND_MASTERCARD;
      end else if ((count inside {5'd13, 5'd16}) && lead == 4'd4) begin
         res = BRAND_VISA;
      end
      return res;
   endfunction

endpackage

/* hw/rtl/lcnc_req_if.sv */
// request channel carrying one card number per transaction
// depends on lcnc_pkg
`timescale 1ns / 1ps

interface lcnc_req_if;
   logic                           valid;
   logic                           ready;
   logic [lcnc_pkg::CARD_WIDTH-1:0] card_number;

   modport source (output valid, output card_number, input ready);
   modport sink   (input valid, input card_number, output ready);
endinterface

/* hw/rtl/lcnc_rsp_if.sv */
// response channel carrying the check result of one card number
// depends on lcnc_pkg
`timescale 1ns / 1ps

interface lcnc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             luhn_ok;
   logic [lcnc_pkg::BRAND_WIDTH-1:0] brand;
   logic [lcnc_pkg::COUNT_WIDTH-1:0] digit_count;

   modport source (output valid, output luhn_ok, output brand, output digit_count,
                   input ready);
   modport sink   (input valid, input luhn_ok, input brand, input digit_count,
                   output ready);
endinterface

/* hw/rtl/lcnc_bcd_step.sv */
// shift-add-3 binary to bcd step, several input bits per cycle
// depends on lcnc_pkg
`timescale 1ns / 1ps

module lcnc_bcd_step #(
   parameter int NUM_DIGITS = lcnc_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic [lcnc_pkg::DIGIT_WIDTH*NUM_DIGITS-1:0] bcd_i,
   input  logic [lcnc_pkg::SHIFT_STEP-1:0]             bits_i,
   output logic [lcnc_pkg::DIGIT_WIDTH*NUM_DIGITS-1:0] bcd_o
);

   localparam int DW = lcnc_pkg::DIGIT_WIDTH;
   localparam int BW = DW * NUM_DIGITS;

   logic [BW-1:0] work;
   logic [DW-1:0] dig;

   always_comb begin
      work = bcd_i;
      dig  = '0;
      for (int s = 0; s < lcnc_pkg::SHIFT_STEP; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            dig = work[d*DW +: DW];
            if (dig >= 4'd5) begin
               work[d*DW +: DW] = dig + 4'd3;
            end
         end
         // top digit carry dropped, keeps the value modulo 10^NUM_DIGITS
         work = {work[BW-2:0], bits_i[lcnc_pkg::SHIFT_STEP-1-s]};
      end
      bcd_o = work;
   end

endmodule

/* hw/rtl/lcnc_luhn_acc.sv */
// luhn digit accumulator: running sum modulo ten, digit count and leading digits
// depends on lcnc_pkg
`timescale 1ns / 1ps

module lcnc_luhn_acc (
   input  logic                              clock,
   input  lcnc_pkg::acc_ctrl_type            ctrl_i,
   input  logic [lcnc_pkg::DIGIT_WIDTH-1:0]  digit_i,
   output lcnc_pkg::acc_status_type          status_o
);

   localparam int DW = lcnc_pkg::DIGIT_WIDTH;
   localparam int CW = lcnc_pkg::COUNT_WIDTH;

   logic [DW-1:0] sum_ff,   sum_in;
   logic          odd_ff,   odd_in;
   logic [CW-1:0] count_ff, count_in;
   logic [DW-1:0] lead_ff,  lead_in;
   logic [DW-1:0] next_ff,  next_in;
   logic [DW-1:0] contrib;
   logic [DW:0]   total;

   always_comb begin
      contrib  = odd_ff ? lcnc_pkg::luhn_double(digit_i) : digit_i;
      total    = {1'b0, sum_ff} + {1'b0, contrib};
      sum_in   = sum_ff;
      odd_in   = odd_ff;
      count_in = count_ff;
      lead_in  = lead_ff;
      next_in  = next_ff;
      if (ctrl_i.clear) begin
         sum_in   = '0;
         odd_in   = 1'b0;
         count_in = '0;
         lead_in  = '0;
         next_in  = '0;
      end else if (ctrl_i.step) begin
         sum_in   = (total >= 5'd10) ? DW'(total - 5'd10) : total[DW-1:0];
         odd_in   = !odd_ff;
         count_in = count_ff + 1'b1;
         next_in  = lead_ff;
         lead_in  = digit_i;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      odd_ff   <= odd_in;
      count_ff <= count_in;
      lead_ff  <= lead_in;
      next_ff  <= next_in;
   end

   assign status_o.sum_zero = (sum_ff == '0);
   assign status_o.count    = count_ff;
   assign status_o.lead     = lead_ff;
   assign status_o.next     = next_ff;

endmodule

/* hw/rtl/luhn_card_number_check_core.sv */
// luhn card number check core: sequencer, bcd conversion register, response register
// depends on lcnc_pkg, lcnc_req_if, lcnc_rsp_if, lcnc_bcd_step, lcnc_luhn_acc
//
// usage
//   req_ch carries one card number per transaction (valid/ready, taken when both high)
//   rsp_ch returns luhn_ok, brand and digit_count for each request, in order
//   req_ch.ready is high only while the core is idle, one number is worked at a time
//   work on a request runs in order: a load step, conversion at 4 bits per cycle
//     through the single shift-add-3 unit, the digits one by one through the luhn
//     accumulator until the remaining bcd value is zero, and a response step
//   a new number is taken only after the previous one has left the sequencer
//   a new request is taken while the previous response still waits in its register
//   if the receiver stalls, the finished result waits in the sequencer until the
//   response register is free, and no further request is taken meanwhile
//   reset is synchronous, active high, and returns the core to idle with no
//   response pending; req_ch.ready stays low while reset is high
`timescale 1ns / 1ps

module luhn_card_number_check_core #(
   parameter int MAX_DIGITS = lcnc_pkg::MAX_DIGITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   lcnc_req_if.sink  req_ch,
   lcnc_rsp_if.source rsp_ch
);

   localparam int BcdWidth  = lcnc_pkg::DIGIT_WIDTH * MAX_DIGITS;
   localparam int CntWidth  = lcnc_pkg::CONV_CNT_WIDTH;
   localparam int ConvWidth = lcnc_pkg::CONV_WIDTH;
   localparam int Step      = lcnc_pkg::SHIFT_STEP;
   localparam logic [CntWidth-1:0] ConvLast = CntWidth'(lcnc_pkg::CONV_CYCLES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                        state_ff,     state_in;
   logic [ConvWidth-1:0]             bits_ff,      bits_in;
   logic [CntWidth-1:0]              conv_cnt_ff,  conv_cnt_in;
   logic [BcdWidth-1:0]              bcd_ff,       bcd_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_ok_ff,    rsp_ok_in;
   logic [lcnc_pkg::BRAND_WIDTH-1:0] rsp_brand_ff, rsp_brand_in;
   logic [lcnc_pkg::COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   logic [BcdWidth-1:0]              bcd_next;
   lcnc_pkg::acc_ctrl_type           acc_ctrl;
   lcnc_pkg::acc_status_type         acc_status;
   logic                             req_take;
   logic                             rsp_free;

   lcnc_bcd_step #(
      .NUM_DIGITS (MAX_DIGITS)
   ) u_bcd_step (
      .bcd_i  (bcd_ff),
      .bits_i (bits_ff[ConvWidth-1 -: Step]),
      .bcd_o  (bcd_next)
   );

   lcnc_luhn_acc u_luhn_acc (
      .clock    (clock),
      .ctrl_i   (acc_ctrl),
      .digit_i  (bcd_ff[lcnc_pkg::DIGIT_WIDTH-1:0]),
      .status_o (acc_status)
   );

   assign req_ch.ready = (state_ff == ST_IDLE) && !reset;
   assign req_take     = req_ch.valid && (state_ff == ST_IDLE);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in       = state_ff;
      bits_in        = bits_ff;
      conv_cnt_in    = conv_cnt_ff;
      bcd_in         = bcd_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_ok_in      = rsp_ok_ff;
      rsp_brand_in   = rsp_brand_ff;
      rsp_count_in   = rsp_count_ff;
      acc_ctrl.clear = 1'b0;
      acc_ctrl.step  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               bits_in        = {1'b0, req_ch.card_number};
               conv_cnt_in    = '0;
               bcd_in         = '0;
               acc_ctrl.clear = 1'b1;
               state_in       = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in      = bcd_next;
            bits_in     = bits_ff << Step;
            conv_cnt_in = conv_cnt_ff + 1'b1;
            if (conv_cnt_ff == ConvLast) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (bcd_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               acc_ctrl.step = 1'b1;
               bcd_in        = bcd_ff >> lcnc_pkg::DIGIT_WIDTH;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = acc_status.sum_zero;
               rsp_brand_in = acc_status.sum_zero
                            ? lcnc_pkg::classify(acc_status.count, acc_status.lead,
                                                 acc_status.next)
                            : lcnc_pkg::BRAND_NONE;
               rsp_count_in = acc_status.count;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bits_ff      <= bits_in;
      conv_cnt_ff  <= conv_cnt_in;
      bcd_ff       <= bcd_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_brand_ff <= rsp_brand_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.luhn_ok     = rsp_ok_ff;
   assign rsp_ch.brand       = rsp_brand_ff;
   assign rsp_ch.digit_count = rsp_count_ff;

endmodule
